@@ src/tod_pkg.sv @@
// types, constants and helper functions shared by the time-of-day clock files
// no dependencies
package tod_pkg;

  localparam int unsigned DIGITS = 8;
  localparam int unsigned DIG_W = $clog2(DIGITS);

  localparam logic [6:0] DASH_PATTERN = 7'h40;
  localparam logic [7:0] TICKS_RESET = 8'd10;
  localparam logic [7:0] SCAN_RESET = 8'd3;

  localparam logic [4:0] HOURS_MAX = 5'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;

  typedef enum logic [2:0] {
    OP_FAST = 3'd0,
    OP_SLOW = 3'd1,
    OP_SET  = 3'd2,
    OP_ADD  = 3'd3,
    OP_READ = 3'd4
  } op_e;

  typedef enum logic [0:0] {
    REG_TICKS = 1'b0,
    REG_SCAN  = 1'b1
  } reg_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic       hold;
    logic [6:0] arg_hours;
    logic [6:0] arg_minutes;
    logic [6:0] arg_seconds;
  } cmd_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } tod_time_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] ones;
  } dec_t;

  typedef struct packed {
    logic [6:0] segments;
    logic [7:0] select;
    logic       update;
  } scan_t;

  function automatic logic [6:0] seg_of(input logic [3:0] d);
    logic [6:0] p;
    case (d)
      4'd0: p = 7'h3f;
      4'd1: p = 7'h06;
      4'd2: p = 7'h5b;
      4'd3: p = 7'h4f;
      4'd4: p = 7'h66;
      4'd5: p = 7'h6d;
      4'd6: p = 7'h7d;
      4'd7: p = 7'h07;
      4'd8: p = 7'h7f;
      4'd9: p = 7'h6f;
      default: p = 7'h00;
    endcase
    return p;
  endfunction

  // values stay below 64, so the tens digit comes from a few compares
  function automatic dec_t split_dec(input logic [5:0] v);
    dec_t r;
    logic [5:0] rest;
    if (v >= 6'd60) begin
      r.tens = 4'd6; rest = v - 6'd60;
    end else if (v >= 6'd50) begin
      r.tens = 4'd5; rest = v - 6'd50;
    end else if (v >= 6'd40) begin
      r.tens = 4'd4; rest = v - 6'd40;
    end else if (v >= 6'd30) begin
      r.tens = 4'd3; rest = v - 6'd30;
    end else if (v >= 6'd20) begin
      r.tens = 4'd2; rest = v - 6'd20;
    end else if (v >= 6'd10) begin
      r.tens = 4'd1; rest = v - 6'd10;
    end else begin
      r.tens = 4'd0; rest = v;
    end
    r.ones = rest[3:0];
    return r;
  endfunction

endpackage

@@ src/tod_time.sv @@
// hours:minutes:seconds registers with the slow tick, set and add updates
// depends on tod_pkg
module tod_time import tod_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  cmd_t       cmd_i,
  input  logic [7:0] ticks_per_sec_i,
  output tod_time_t  now_o,
  output tod_time_t  next_o
);

  tod_time_t  time_q, time_d;
  logic [7:0] sub_q, sub_d;

  logic [7:0] sub_inc;
  logic [7:0] sec_sum, min_sum, hr_sum, sec_rem, min_rem;
  logic [1:0] sec_cy, min_cy;
  logic [7:0] hr_rem;
  tod_time_t  tick_time;

  // one second forward with carries
  always_comb begin
    tick_time = time_q;
    if (time_q.seconds >= MINSEC_MAX) begin
      tick_time.seconds = '0;
      if (time_q.minutes >= MINSEC_MAX) begin
        tick_time.minutes = '0;
        tick_time.hours = (time_q.hours >= HOURS_MAX) ? 5'd0 : time_q.hours + 5'd1;
      end else begin
        tick_time.minutes = time_q.minutes + 6'd1;
      end
    end else begin
      tick_time.seconds = time_q.seconds + 6'd1;
    end
  end

  // add offset: sums stay below 192, so carries are 0 to 3
  always_comb begin
    sec_sum = {2'b00, time_q.seconds} + {1'b0, cmd_i.arg_seconds};
    if (sec_sum >= 8'd180) begin
      sec_cy = 2'd3; sec_rem = sec_sum - 8'd180;
    end else if (sec_sum >= 8'd120) begin
      sec_cy = 2'd2; sec_rem = sec_sum - 8'd120;
    end else if (sec_sum >= 8'd60) begin
      sec_cy = 2'd1; sec_rem = sec_sum - 8'd60;
    end else begin
      sec_cy = 2'd0; sec_rem = sec_sum;
    end
    min_sum = {2'b00, time_q.minutes} + {1'b0, cmd_i.arg_minutes} + {6'd0, sec_cy};
    if (min_sum >= 8'd180) begin
      min_cy = 2'd3; min_rem = min_sum - 8'd180;
    end else if (min_sum >= 8'd120) begin
      min_cy = 2'd2; min_rem = min_sum - 8'd120;
    end else if (min_sum >= 8'd60) begin
      min_cy = 2'd1; min_rem = min_sum - 8'd60;
    end else begin
      min_cy = 2'd0; min_rem = min_sum;
    end
    hr_sum = {3'b000, time_q.hours} + {1'b0, cmd_i.arg_hours} + {6'd0, min_cy};
    if (hr_sum >= 8'd144)      hr_rem = hr_sum - 8'd144;
    else if (hr_sum >= 8'd120) hr_rem = hr_sum - 8'd120;
    else if (hr_sum >= 8'd96)  hr_rem = hr_sum - 8'd96;
    else if (hr_sum >= 8'd72)  hr_rem = hr_sum - 8'd72;
    else if (hr_sum >= 8'd48)  hr_rem = hr_sum - 8'd48;
    else if (hr_sum >= 8'd24)  hr_rem = hr_sum - 8'd24;
    else                       hr_rem = hr_sum;
  end

  always_comb begin
    time_d  = time_q;
    sub_d   = sub_q;
    sub_inc = sub_q + 8'd1;
    case (op_e'(cmd_i.opcode))
      OP_SLOW: begin
        if (!cmd_i.hold) begin
          if (sub_inc >= ticks_per_sec_i) begin
            sub_d  = '0;
            time_d = tick_time;
          end else begin
            sub_d = sub_inc;
          end
        end
      end
      OP_SET: begin
        time_d.hours   = (cmd_i.arg_hours > 7'd23) ? HOURS_MAX : cmd_i.arg_hours[4:0];
        time_d.minutes = (cmd_i.arg_minutes > 7'd59) ? MINSEC_MAX : cmd_i.arg_minutes[5:0];
        time_d.seconds = (cmd_i.arg_seconds > 7'd59) ? MINSEC_MAX : cmd_i.arg_seconds[5:0];
      end
      OP_ADD: begin
        time_d.hours   = hr_rem[4:0];
        time_d.minutes = min_rem[5:0];
        time_d.seconds = sec_rem[5:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
      sub_q  <= '0;
    end else if (en_i) begin
      time_q <= time_d;
      sub_q  <= sub_d;
    end
  end

  assign now_o  = time_q;
  assign next_o = time_d;

endmodule

@@ src/tod_scan.sv @@
// display scan: prescaler, digit position and held segment pattern and select
// depends on tod_pkg
module tod_scan import tod_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [2:0] opcode_i,
  input  tod_time_t  time_i,
  input  logic [7:0] scan_divide_i,
  output scan_t      next_o
);

  logic [7:0]       pre_q, pre_d;
  logic [DIG_W-1:0] idx_q, idx_d;
  logic [6:0]       seg_q, seg_d;
  logic [7:0]       sel_q, sel_d;
  logic             upd;
  logic [7:0]       pre_inc;
  logic [6:0]       pattern;
  dec_t             hr_dec, min_dec, sec_dec;

  assign hr_dec  = split_dec({1'b0, time_i.hours});
  assign min_dec = split_dec(time_i.minutes);
  assign sec_dec = split_dec(time_i.seconds);

  // positions: H H - M M - S S, position 0 leftmost
  always_comb begin
    case (idx_q)
      3'd0: pattern = seg_of(hr_dec.tens);
      3'd1: pattern = seg_of(hr_dec.ones);
      3'd3: pattern = seg_of(min_dec.tens);
      3'd4: pattern = seg_of(min_dec.ones);
      3'd6: pattern = seg_of(sec_dec.tens);
      3'd7: pattern = seg_of(sec_dec.ones);
      default: pattern = DASH_PATTERN;
    endcase
  end

  always_comb begin
    pre_d   = pre_q;
    idx_d   = idx_q;
    seg_d   = seg_q;
    sel_d   = sel_q;
    upd     = 1'b0;
    pre_inc = pre_q + 8'd1;
    if (op_e'(opcode_i) == OP_FAST) begin
      if (pre_inc >= scan_divide_i) begin
        pre_d = '0;
        seg_d = pattern;
        sel_d = 8'(1) << idx_q;
        idx_d = idx_q + DIG_W'(1);
        upd   = 1'b1;
      end else begin
        pre_d = pre_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q <= '0;
      idx_q <= '0;
      seg_q <= '0;
      sel_q <= '0;
    end else if (en_i) begin
      pre_q <= pre_d;
      idx_q <= idx_d;
      seg_q <= seg_d;
      sel_q <= sel_d;
    end
  end

  assign next_o.segments = seg_d;
  assign next_o.select   = sel_d;
  assign next_o.update   = upd;

endmodule

@@ src/time_of_day_clock_with_display_scan.sv @@
// top level: stream ports, request register, result register, config registers
// depends on tod_pkg, tod_time and tod_scan
// an accepted request waits in the request register until the result register is free
// throughput: one request per cycle while m_axis_tready is high, set by the single update
// pass of the time and scan registers between the request and result registers
// reset: time, sub-second count, scan state and held display clear to zero,
// registers return to 10 slow ticks per second and a scan divide of 3
module time_of_day_clock_with_display_scan import tod_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // hold, arg_hours, arg_minutes, arg_seconds from bit 0 up, zero filled
  input  logic [23:0] s_axis_tdata,
  // opcode
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // hours_now, minutes_now, seconds_now, segments, digit_select from bit 0 up
  output logic [31:0] m_axis_tdata,
  // display_update
  output logic [0:0]  m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        in_valid_q, in_valid_d;
  cmd_t        cmd_q;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_data_q;
  logic        out_upd_q;
  logic [7:0]  ticks_q, scan_q;
  logic        s_acc, advance, cfg_wr;
  tod_time_t   time_now, time_next;
  scan_t       scan_next;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= TICKS_RESET;
      scan_q  <= SCAN_RESET;
    end else if (cfg_wr) begin
      case (reg_e'(paddr[2]))
        REG_TICKS: ticks_q <= pwdata[7:0];
        REG_SCAN:  scan_q  <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[2]))
      REG_TICKS: prdata = {24'd0, ticks_q};
      REG_SCAN:  prdata = {24'd0, scan_q};
      default:   prdata = '0;
    endcase
  end

  // the request register moves on when it holds a request and the result register is free or being taken
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign s_acc         = s_axis_tvalid & s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_acc)        in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (advance)            out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      cmd_q.opcode      <= s_axis_tuser;
      cmd_q.hold        <= s_axis_tdata[0];
      cmd_q.arg_hours   <= s_axis_tdata[7:1];
      cmd_q.arg_minutes <= s_axis_tdata[14:8];
      cmd_q.arg_seconds <= s_axis_tdata[21:15];
    end
    if (advance) begin
      out_data_q <= {scan_next.select, scan_next.segments, time_next.seconds,
                     time_next.minutes, time_next.hours};
      out_upd_q  <= scan_next.update;
    end
  end

  tod_time u_time (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (advance),
    .cmd_i           (cmd_q),
    .ticks_per_sec_i (ticks_q),
    .now_o           (time_now),
    .next_o          (time_next)
  );

  tod_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .opcode_i      (cmd_q.opcode),
    .time_i        (time_now),
    .scan_divide_i (scan_q),
    .next_o        (scan_next)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_upd_q;

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    time_now.hours <= HOURS_MAX && time_now.minutes <= MINSEC_MAX
      && time_now.seconds <= MINSEC_MAX)
    else $error("time register out of range");

  a_update_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_upd_q |-> $onehot(out_data_q[31:24]))
    else $error("scan update without a one-hot digit select");

  a_no_advance_without_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |=> $stable(time_now))
    else $error("time changed with no request in flight");

  a_result_follows_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced request did not reach the result register");

endmodule
